// ===== rtl/jac_pkg.sv =====
`timescale 1ns / 1ps

package jac_pkg;

  // Sample and window entry widths
  localparam int RAW_W   = 12;
  localparam int ENTRY_W = 12;
  localparam int AXIS_W  = 11;

  // Moving-average window (power of two length)
  localparam int WINDOW_LEN = 8;
  localparam int WIN_LOG2   = $clog2(WINDOW_LEN);
  localparam int SUM_W      = ENTRY_W + WIN_LOG2;

  // Zero-point calibration (power of two sample count)
  localparam int CAL_SAMPLES = 32;
  localparam int CAL_LOG2    = $clog2(CAL_SAMPLES);
  localparam int CAL_SUM_W   = RAW_W + CAL_LOG2;

  // Offset scaling by SCALE_NUM / 2**SCALE_SHIFT
  localparam int SCALE_NUM   = 2000;
  localparam int SCALE_SHIFT = 12;
  localparam int DIFF_W      = RAW_W + 1;
  localparam int PROD_W      = 24;

  // Output clamp limit
  localparam int AXIS_LIMIT = 1000;

  // One window entry for both axes
  typedef struct packed {
    logic signed [ENTRY_W-1:0] x;
    logic signed [ENTRY_W-1:0] y;
  } jac_pair_t;

endpackage

// ===== rtl/jac_cell.sv =====
`timescale 1ns / 1ps

module jac_cell
  import jac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  jac_pair_t din,
  output jac_pair_t q
);

  jac_pair_t entry;

  // Take the neighbor's entry on each window advance; start cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (shift) begin
      entry <= din;
    end
  end

  assign q = entry;

endmodule

// ===== rtl/joystick_axis_conditioner.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Content
// s_axis    in   tdata: raw_x[11:0], raw_y[23:12], button_level[24], zero fill
// m_axis    out  tdata: axis_x[10:0], axis_y[21:11], pressed[22]; tuser: calibrated
//
// One item per cycle while the output accepts; stage one feeds the output register.
// Stage one scales the axis offsets (one constant multiply per axis), stage two
// advances the row of window cells and updates the running sums.
// Reset clears calibration, window cells and running sums; no clearing pass.
// A stalled output holds its item while stage one still takes one more item.
module joystick_axis_conditioner
  import jac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // raw_x, raw_y, button_level
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // axis_x, axis_y, pressed
  output logic        m_axis_tuser    // calibrated
);

  localparam logic signed [PROD_W-1:0] ScaleK    = PROD_W'(SCALE_NUM);
  localparam logic signed [PROD_W-1:0] ScaleRnd  = PROD_W'((1 << SCALE_SHIFT) - 1);
  localparam logic signed [SUM_W-1:0]  MeanRnd   = SUM_W'(WINDOW_LEN - 1);
  localparam logic signed [ENTRY_W-1:0] LimitHi  = ENTRY_W'(AXIS_LIMIT);
  localparam logic signed [ENTRY_W-1:0] LimitLo  = -ENTRY_W'(AXIS_LIMIT);

  // Input fields
  logic [RAW_W-1:0] raw_x;
  logic [RAW_W-1:0] raw_y;
  logic             button_level;
  logic             in_fire;
  logic             move;

  assign raw_x        = s_axis_tdata[RAW_W-1:0];
  assign raw_y        = s_axis_tdata[2*RAW_W-1:RAW_W];
  assign button_level = s_axis_tdata[2*RAW_W];

  // Calibration state
  logic [CAL_LOG2-1:0]  cal_count;
  logic                 cal_done;
  logic [CAL_SUM_W-1:0] cal_sum_x;
  logic [CAL_SUM_W-1:0] cal_sum_y;
  logic [CAL_SUM_W-1:0] cal_sum_x_next;
  logic [CAL_SUM_W-1:0] cal_sum_y_next;
  logic [RAW_W-1:0]     zero_x;
  logic [RAW_W-1:0]     zero_y;

  assign cal_sum_x_next = cal_sum_x + CAL_SUM_W'(raw_x);
  assign cal_sum_y_next = cal_sum_y + CAL_SUM_W'(raw_y);

  // Accumulate the first samples, then set the zero points to their floor mean
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_count <= '0;
      cal_done  <= 1'b0;
      cal_sum_x <= '0;
      cal_sum_y <= '0;
      zero_x    <= '0;
      zero_y    <= '0;
    end else if (in_fire && !cal_done) begin
      cal_count <= cal_count + CAL_LOG2'(1);
      cal_sum_x <= cal_sum_x_next;
      cal_sum_y <= cal_sum_y_next;
      if (cal_count == CAL_LOG2'(CAL_SAMPLES - 1)) begin
        cal_done <= 1'b1;
        zero_x   <= cal_sum_x_next[CAL_SUM_W-1:CAL_LOG2];
        zero_y   <= cal_sum_y_next[CAL_SUM_W-1:CAL_LOG2];
      end
    end
  end

  // Offset and scale, truncating toward zero
  logic signed [DIFF_W-1:0]  diff_x;
  logic signed [DIFF_W-1:0]  diff_y;
  logic signed [PROD_W-1:0]  prod_x;
  logic signed [PROD_W-1:0]  prod_y;
  logic signed [PROD_W-1:0]  adj_x;
  logic signed [PROD_W-1:0]  adj_y;

  assign diff_x = $signed({1'b0, zero_x}) - $signed({1'b0, raw_x});
  assign diff_y = $signed({1'b0, raw_y}) - $signed({1'b0, zero_y});
  assign prod_x = PROD_W'(diff_x) * ScaleK;
  assign prod_y = PROD_W'(diff_y) * ScaleK;
  assign adj_x  = prod_x + (prod_x[PROD_W-1] ? ScaleRnd : '0);
  assign adj_y  = prod_y + (prod_y[PROD_W-1] ? ScaleRnd : '0);

  // Stage one register
  logic      s1_valid;
  logic      s1_cal;
  logic      s1_pressed;
  jac_pair_t s1_val;

  assign move          = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || move;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cal     <= cal_done;
      s1_pressed <= !button_level;
      s1_val.x   <= adj_x[PROD_W-1:SCALE_SHIFT];
      s1_val.y   <= adj_y[PROD_W-1:SCALE_SHIFT];
    end
  end

  // Row of window cells, oldest entry at the far end
  logic      shift;
  jac_pair_t cell_q [WINDOW_LEN];

  assign shift = move && s1_valid && s1_cal;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    jac_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .din   ((i == 0) ? s1_val : cell_q[(i == 0) ? 0 : i-1]),
      .q     (cell_q[i])
    );
  end

  // Running sums and clamped means
  logic signed [SUM_W-1:0]   run_sum_x;
  logic signed [SUM_W-1:0]   run_sum_y;
  logic signed [SUM_W-1:0]   run_sum_x_next;
  logic signed [SUM_W-1:0]   run_sum_y_next;
  logic signed [SUM_W-1:0]   madj_x;
  logic signed [SUM_W-1:0]   madj_y;
  logic signed [ENTRY_W-1:0] mean_x;
  logic signed [ENTRY_W-1:0] mean_y;
  logic signed [ENTRY_W-1:0] clip_x;
  logic signed [ENTRY_W-1:0] clip_y;

  assign run_sum_x_next = run_sum_x + SUM_W'(s1_val.x) - SUM_W'(cell_q[WINDOW_LEN-1].x);
  assign run_sum_y_next = run_sum_y + SUM_W'(s1_val.y) - SUM_W'(cell_q[WINDOW_LEN-1].y);
  assign madj_x = run_sum_x_next + (run_sum_x_next[SUM_W-1] ? MeanRnd : '0);
  assign madj_y = run_sum_y_next + (run_sum_y_next[SUM_W-1] ? MeanRnd : '0);
  assign mean_x = madj_x[SUM_W-1:WIN_LOG2];
  assign mean_y = madj_y[SUM_W-1:WIN_LOG2];

  always_comb begin
    priority if (mean_x > LimitHi) begin
      clip_x = LimitHi;
    end else if (mean_x < LimitLo) begin
      clip_x = LimitLo;
    end else begin
      clip_x = mean_x;
    end
    priority if (mean_y > LimitHi) begin
      clip_y = LimitHi;
    end else if (mean_y < LimitLo) begin
      clip_y = LimitLo;
    end else begin
      clip_y = mean_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum_x <= '0;
      run_sum_y <= '0;
    end else if (shift) begin
      run_sum_x <= run_sum_x_next;
      run_sum_y <= run_sum_y_next;
    end
  end

  // Output register
  logic                     out_valid;
  logic signed [AXIS_W-1:0] axis_x;
  logic signed [AXIS_W-1:0] axis_y;
  logic                     pressed;
  logic                     calibrated;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move && s1_valid) begin
      pressed    <= s1_pressed;
      calibrated <= s1_cal;
      axis_x     <= s1_cal ? clip_x[AXIS_W-1:0] : '0;
      axis_y     <= s1_cal ? clip_y[AXIS_W-1:0] : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, pressed, axis_y, axis_x};
  assign m_axis_tuser  = calibrated;

endmodule
